@@ src/dcfs_pkg.sv @@
// Shared types, constants and the microcode ROM of the dual curve fan speed block.
// Used by dcfs_seq, dcfs_path and the top level; depends on nothing.
package dcfs_pkg;

	// Curve table geometry.
	localparam int MAX_POINTS = 8;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 4;
	localparam int PC_W       = 4;

	// Request opcodes.
	localparam logic [1:0] OP_EVAL   = 2'd0;
	localparam logic [1:0] OP_WR_TMP = 2'd1;
	localparam logic [1:0] OP_WR_HUM = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_TEMP_POINTS = 1'b0;
	localparam logic CFG_HUM_POINTS  = 1'b1;

	// Reset point counts.
	localparam logic [CNT_W-1:0] TEMP_POINTS_RST = 4'd5;
	localparam logic [CNT_W-1:0] HUM_POINTS_RST  = 4'd4;

	// One curve point: signed threshold in 1/16 units and a fan percentage.
	typedef struct packed {
		logic signed [15:0] th;
		logic [7:0]         fan;
	} point_t;

	// Micro-operations executed by the datapath.
	typedef enum logic [3:0] {
		UOP_INIT,
		UOP_CHK_EMPTY,
		UOP_CHK_FIRST,
		UOP_CHK_LAST,
		UOP_LOAD_LO,
		UOP_LOAD_HI,
		UOP_ADVANCE,
		UOP_NO_MATCH,
		UOP_SPAN,
		UOP_MUL_LO,
		UOP_MUL_HI,
		UOP_DIV,
		UOP_QUOT,
		UOP_STORE,
		UOP_FINISH
	} uop_t;

	// One control word: operation, conditional jump enable and target.
	typedef struct packed {
		uop_t            uop;
		logic            jump;
		logic [PC_W-1:0] target;
	} cw_t;

	// Sequencer outputs seen by the datapath.
	typedef struct packed {
		logic run;
		cw_t  cw;
	} ctrl_t;

	// Program step addresses.
	localparam logic [PC_W-1:0] STEP_INIT     = 4'd0;
	localparam logic [PC_W-1:0] STEP_EMPTY    = 4'd1;
	localparam logic [PC_W-1:0] STEP_FIRST    = 4'd2;
	localparam logic [PC_W-1:0] STEP_LAST     = 4'd3;
	localparam logic [PC_W-1:0] STEP_LOAD_LO  = 4'd4;
	localparam logic [PC_W-1:0] STEP_LOAD_HI  = 4'd5;
	localparam logic [PC_W-1:0] STEP_ADVANCE  = 4'd6;
	localparam logic [PC_W-1:0] STEP_NO_MATCH = 4'd7;
	localparam logic [PC_W-1:0] STEP_SPAN     = 4'd8;
	localparam logic [PC_W-1:0] STEP_MUL_LO   = 4'd9;
	localparam logic [PC_W-1:0] STEP_MUL_HI   = 4'd10;
	localparam logic [PC_W-1:0] STEP_DIV      = 4'd11;
	localparam logic [PC_W-1:0] STEP_QUOT     = 4'd12;
	localparam logic [PC_W-1:0] STEP_STORE    = 4'd13;
	localparam logic [PC_W-1:0] STEP_FINISH   = 4'd14;

	// Microcode ROM. The program runs once per curve; STORE loops back for the second.
	function automatic cw_t ucode_rom(input logic [PC_W-1:0] pc);
		cw_t cw;
		cw = '{uop: UOP_FINISH, jump: 1'b0, target: STEP_INIT};
		unique case (pc)
			STEP_INIT:     cw = '{uop: UOP_INIT,      jump: 1'b0, target: STEP_INIT};
			STEP_EMPTY:    cw = '{uop: UOP_CHK_EMPTY, jump: 1'b1, target: STEP_STORE};
			STEP_FIRST:    cw = '{uop: UOP_CHK_FIRST, jump: 1'b1, target: STEP_STORE};
			STEP_LAST:     cw = '{uop: UOP_CHK_LAST,  jump: 1'b1, target: STEP_STORE};
			STEP_LOAD_LO:  cw = '{uop: UOP_LOAD_LO,   jump: 1'b0, target: STEP_INIT};
			STEP_LOAD_HI:  cw = '{uop: UOP_LOAD_HI,   jump: 1'b1, target: STEP_SPAN};
			STEP_ADVANCE:  cw = '{uop: UOP_ADVANCE,   jump: 1'b1, target: STEP_LOAD_HI};
			STEP_NO_MATCH: cw = '{uop: UOP_NO_MATCH,  jump: 1'b1, target: STEP_STORE};
			STEP_SPAN:     cw = '{uop: UOP_SPAN,      jump: 1'b0, target: STEP_INIT};
			STEP_MUL_LO:   cw = '{uop: UOP_MUL_LO,    jump: 1'b0, target: STEP_INIT};
			STEP_MUL_HI:   cw = '{uop: UOP_MUL_HI,    jump: 1'b0, target: STEP_INIT};
			STEP_DIV:      cw = '{uop: UOP_DIV,       jump: 1'b1, target: STEP_DIV};
			STEP_QUOT:     cw = '{uop: UOP_QUOT,      jump: 1'b0, target: STEP_INIT};
			STEP_STORE:    cw = '{uop: UOP_STORE,     jump: 1'b1, target: STEP_INIT};
			STEP_FINISH:   cw = '{uop: UOP_FINISH,    jump: 1'b0, target: STEP_INIT};
			default:       cw = '{uop: UOP_FINISH,    jump: 1'b0, target: STEP_INIT};
		endcase
		return cw;
	endfunction

	// Default curve points loaded at reset; unused slots are zero.
	function automatic point_t dflt_point(input logic hum, input logic [IDX_W-1:0] idx);
		point_t p;
		p = '0;
		if (!hum) begin
			unique case (idx)
				3'd0:    p = '{th: 16'sd240, fan: 8'd0};
				3'd1:    p = '{th: 16'sd320, fan: 8'd30};
				3'd2:    p = '{th: 16'sd400, fan: 8'd50};
				3'd3:    p = '{th: 16'sd480, fan: 8'd80};
				3'd4:    p = '{th: 16'sd560, fan: 8'd100};
				default: p = '0;
			endcase
		end else begin
			unique case (idx)
				3'd0:    p = '{th: 16'sd480,  fan: 8'd0};
				3'd1:    p = '{th: 16'sd640,  fan: 8'd40};
				3'd2:    p = '{th: 16'sd960,  fan: 8'd60};
				3'd3:    p = '{th: 16'sd1280, fan: 8'd100};
				default: p = '0;
			endcase
		end
		return p;
	endfunction

endpackage

@@ src/dual_curve_fan_speed.sv @@
// Evaluate requests run from acceptance to the done strobe through the segment walk (two
// steps per segment) and the 8-step restoring divide, done on one shared datapath for each
// curve in turn. One evaluate is in flight at a time.
// Point writes take effect at the accepting edge and raise no strobe.
// Reset is asynchronous, active low, and restores the default curves and point counts.
// The receiver cannot stall: each result is shown for one cycle with done high.
module dual_curve_fan_speed (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] temperature,
	input  logic signed [15:0] humidity,
	input  logic [2:0]         point_index,
	input  logic signed [15:0] point_threshold,
	input  logic [7:0]         point_fan,
	output logic               done,
	output logic [7:0]         fan_speed,
	output logic [7:0]         temp_speed,
	output logic [7:0]         hum_speed,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data
);

	dcfs_pkg::ctrl_t ctrl;
	logic            accept;
	logic            go;
	logic            take;

	// Request decode.
	assign busy      = ctrl.run;
	assign accept    = start && !ctrl.run;
	assign go        = accept && (opcode == dcfs_pkg::OP_EVAL);
	assign cfg_ready = 1'b1;

	dcfs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.take   (take),
		.ctrl   (ctrl)
	);

	dcfs_path u_path (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.go              (go),
		.wr_temp         (accept && (opcode == dcfs_pkg::OP_WR_TMP)),
		.wr_hum          (accept && (opcode == dcfs_pkg::OP_WR_HUM)),
		.temperature     (temperature),
		.humidity        (humidity),
		.point_index     (point_index),
		.point_threshold (point_threshold),
		.point_fan       (point_fan),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.take            (take),
		.done            (done),
		.fan_speed       (fan_speed),
		.temp_speed      (temp_speed),
		.hum_speed       (hum_speed)
	);

endmodule

@@ src/dcfs_seq.sv @@
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on dcfs_pkg.
module dcfs_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic                take,
	output dcfs_pkg::ctrl_t     ctrl
);

	logic [dcfs_pkg::PC_W-1:0] pc_q;
	logic                      run_q;
	dcfs_pkg::cw_t             cw;

	// Current control word.
	assign cw        = dcfs_pkg::ucode_rom(pc_q);
	assign ctrl.run  = run_q;
	assign ctrl.cw   = cw;

	// Step counter: start at step zero, jump when the datapath flags the condition.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= dcfs_pkg::STEP_INIT;
			run_q <= 1'b0;
		end else if (go) begin
			pc_q  <= dcfs_pkg::STEP_INIT;
			run_q <= 1'b1;
		end else if (run_q) begin
			if (cw.uop == dcfs_pkg::UOP_FINISH) begin
				run_q <= 1'b0;
			end else if (cw.jump && take) begin
				pc_q <= cw.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

@@ src/dcfs_path.sv @@
// Datapath: curve tables, point counts, segment walk registers and serial divider.
// Driven by the control word from dcfs_seq; depends on dcfs_pkg.
module dcfs_path (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dcfs_pkg::ctrl_t                ctrl,
	input  logic                           go,
	input  logic                           wr_temp,
	input  logic                           wr_hum,
	input  logic signed [15:0]             temperature,
	input  logic signed [15:0]             humidity,
	input  logic [dcfs_pkg::IDX_W-1:0]     point_index,
	input  logic signed [15:0]             point_threshold,
	input  logic [7:0]                     point_fan,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [dcfs_pkg::CNT_W-1:0]     cfg_data,
	output logic                           take,
	output logic                           done,
	output logic [7:0]                     fan_speed,
	output logic [7:0]                     temp_speed,
	output logic [7:0]                     hum_speed
);

	dcfs_pkg::point_t temp_tab_q [dcfs_pkg::MAX_POINTS];
	dcfs_pkg::point_t hum_tab_q  [dcfs_pkg::MAX_POINTS];

	logic [dcfs_pkg::CNT_W-1:0] temp_points_q;
	logic [dcfs_pkg::CNT_W-1:0] hum_points_q;

	logic signed [15:0]         temp_in_q;
	logic signed [15:0]         hum_in_q;
	logic                       sel_q;
	logic signed [15:0]         x_q;
	logic [dcfs_pkg::CNT_W-1:0] n_q;
	logic [dcfs_pkg::IDX_W-1:0] i_q;
	dcfs_pkg::point_t           lo_q;
	dcfs_pkg::point_t           hi_q;
	logic [7:0]                 last_fan_q;
	logic [16:0]                range_q;
	logic [16:0]                dx_q;
	logic [24:0]                acc_q;
	logic [23:0]                div_q;
	logic [7:0]                 quo_q;
	logic [2:0]                 k_q;
	logic [7:0]                 res_q;
	logic [7:0]                 t_res_q;
	logic                       done_q;
	logic [7:0]                 fan_speed_q;
	logic [7:0]                 temp_speed_q;
	logic [7:0]                 hum_speed_q;

	dcfs_pkg::uop_t             uop;
	logic [dcfs_pkg::IDX_W-1:0] rd_addr;
	dcfs_pkg::point_t           entry;
	logic [dcfs_pkg::CNT_W-1:0] cnt;
	logic signed [16:0]         span_d;
	logic signed [16:0]         dx_d;
	logic [16:0]                rem_d;
	logic [24:0]                prod_lo;
	logic [24:0]                prod_hi;
	logic                       ge;

	assign uop = ctrl.cw.uop;

	// Table read address for the current step.
	always_comb begin
		unique case (uop)
			dcfs_pkg::UOP_CHK_LAST: rd_addr = dcfs_pkg::IDX_W'(n_q - 1'b1);
			dcfs_pkg::UOP_LOAD_HI:  rd_addr = i_q + 1'b1;
			default:                rd_addr = '0;
		endcase
	end

	// Single read port on the curve being evaluated.
	assign entry = sel_q ? hum_tab_q[rd_addr] : temp_tab_q[rd_addr];
	assign cnt   = sel_q ? hum_points_q : temp_points_q;

	// Interpolation arithmetic.
	assign span_d  = 17'(hi_q.th) - 17'(lo_q.th);
	assign dx_d    = 17'(x_q) - 17'(lo_q.th);
	assign rem_d   = range_q - dx_q;
	assign prod_lo = 25'(lo_q.fan) * 25'(rem_d);
	assign prod_hi = 25'(hi_q.fan) * 25'(dx_q);
	assign ge      = acc_q >= {1'b0, div_q};

	// Jump condition for the current step.
	always_comb begin
		unique case (uop)
			dcfs_pkg::UOP_CHK_EMPTY: take = (n_q == '0);
			dcfs_pkg::UOP_CHK_FIRST: take = (x_q <= entry.th);
			dcfs_pkg::UOP_CHK_LAST:  take = (x_q >= entry.th);
			dcfs_pkg::UOP_LOAD_HI:   take = (x_q >= lo_q.th) && (x_q < entry.th);
			dcfs_pkg::UOP_ADVANCE:   take = ((dcfs_pkg::CNT_W'(i_q) + 4'd3) <= n_q);
			dcfs_pkg::UOP_NO_MATCH:  take = 1'b1;
			dcfs_pkg::UOP_DIV:       take = (k_q != '0);
			dcfs_pkg::UOP_STORE:     take = !sel_q;
			default:                 take = 1'b0;
		endcase
	end

	// Tables and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < dcfs_pkg::MAX_POINTS; e++) begin
				temp_tab_q[e] <= dcfs_pkg::dflt_point(1'b0, dcfs_pkg::IDX_W'(e));
				hum_tab_q[e]  <= dcfs_pkg::dflt_point(1'b1, dcfs_pkg::IDX_W'(e));
			end
			temp_points_q <= dcfs_pkg::TEMP_POINTS_RST;
			hum_points_q  <= dcfs_pkg::HUM_POINTS_RST;
		end else begin
			if (wr_temp) begin
				temp_tab_q[point_index] <= '{th: point_threshold, fan: point_fan};
			end
			if (wr_hum) begin
				hum_tab_q[point_index] <= '{th: point_threshold, fan: point_fan};
			end
			if (cfg_we && cfg_index == dcfs_pkg::CFG_TEMP_POINTS) begin
				temp_points_q <= cfg_data;
			end
			if (cfg_we && cfg_index == dcfs_pkg::CFG_HUM_POINTS) begin
				hum_points_q <= cfg_data;
			end
		end
	end

	// Control state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q        <= 1'b0;
			done_q       <= 1'b0;
			fan_speed_q  <= '0;
			temp_speed_q <= '0;
			hum_speed_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				sel_q <= 1'b0;
			end else if (ctrl.run && uop == dcfs_pkg::UOP_STORE) begin
				sel_q <= 1'b1;
			end else if (ctrl.run && uop == dcfs_pkg::UOP_FINISH) begin
				done_q       <= 1'b1;
				temp_speed_q <= t_res_q;
				hum_speed_q  <= res_q;
				fan_speed_q  <= (t_res_q > res_q) ? t_res_q : res_q;
			end
		end
	end

	// Working registers stepped by the microcode.
	always_ff @(posedge clk) begin
		if (go) begin
			temp_in_q <= temperature;
			hum_in_q  <= humidity;
		end
		if (ctrl.run) begin
			unique case (uop)
				dcfs_pkg::UOP_INIT: begin
					x_q <= sel_q ? hum_in_q : temp_in_q;
					n_q <= (cnt > dcfs_pkg::CNT_W'(dcfs_pkg::MAX_POINTS))
						? dcfs_pkg::CNT_W'(dcfs_pkg::MAX_POINTS) : cnt;
					i_q <= '0;
				end
				dcfs_pkg::UOP_CHK_EMPTY: res_q <= '0;
				dcfs_pkg::UOP_CHK_FIRST: res_q <= entry.fan;
				dcfs_pkg::UOP_CHK_LAST: begin
					res_q      <= entry.fan;
					last_fan_q <= entry.fan;
				end
				dcfs_pkg::UOP_LOAD_LO: lo_q <= entry;
				dcfs_pkg::UOP_LOAD_HI: hi_q <= entry;
				dcfs_pkg::UOP_ADVANCE: begin
					lo_q <= hi_q;
					i_q  <= i_q + 1'b1;
				end
				dcfs_pkg::UOP_NO_MATCH: res_q <= last_fan_q;
				dcfs_pkg::UOP_SPAN: begin
					range_q <= 17'(span_d);
					dx_q    <= 17'(dx_d);
				end
				dcfs_pkg::UOP_MUL_LO: acc_q <= prod_lo;
				dcfs_pkg::UOP_MUL_HI: begin
					acc_q <= acc_q + prod_hi;
					div_q <= {range_q, 7'b0};
					k_q   <= 3'd7;
					quo_q <= '0;
				end
				dcfs_pkg::UOP_DIV: begin
					// One restoring quotient bit per step, most significant first.
					if (ge) begin
						acc_q <= acc_q - {1'b0, div_q};
					end
					quo_q <= {quo_q[6:0], ge};
					div_q <= {1'b0, div_q[23:1]};
					k_q   <= k_q - 1'b1;
				end
				dcfs_pkg::UOP_QUOT:  res_q <= quo_q;
				dcfs_pkg::UOP_STORE: begin
					// Keep the temperature speed while the humidity curve runs.
					if (!sel_q) begin
						t_res_q <= res_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign done       = done_q;
	assign fan_speed  = fan_speed_q;
	assign temp_speed = temp_speed_q;
	assign hum_speed  = hum_speed_q;

endmodule

@@ src/dcfs_check.sv @@
// Port-level checker for dual_curve_fan_speed and the bind that attaches it.
// Depends on dcfs_pkg for the opcode names.
module dcfs_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] opcode,
	input  logic       done,
	input  logic [7:0] fan_speed,
	input  logic [7:0] temp_speed,
	input  logic [7:0] hum_speed
);

	// An accepted evaluate request starts the sequencer.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == dcfs_pkg::OP_EVAL |=> busy)
		else $error("evaluate request did not raise busy");

	// Point writes and unused opcodes never occupy the sequencer.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode != dcfs_pkg::OP_EVAL |=> !busy)
		else $error("non-evaluate request raised busy");

	// A result is only shown once the sequencer has released.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// The fan speed is the larger of the two curve speeds.
	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fan_speed >= temp_speed && fan_speed >= hum_speed
			&& (fan_speed == temp_speed || fan_speed == hum_speed))
		else $error("fan speed is not the larger curve speed");

	// Each evaluate produces a single one-cycle strobe.
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

endmodule

bind dual_curve_fan_speed dcfs_check u_dcfs_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.opcode     (opcode),
	.done       (done),
	.fan_speed  (fan_speed),
	.temp_speed (temp_speed),
	.hum_speed  (hum_speed)
);
